FILE: rtl/pcs_pkg.sv
// Shared types, codes and constants of the pixel canvas store.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_WIDTH_DEF   = 64;
    localparam int MAX_HEIGHT_DEF  = 32;
    localparam int STORE_BYTES_DEF = 6144;

    // Field widths
    localparam int ACTION_W = 3;
    localparam int COORD_W  = 16;
    localparam int COLOR_W  = 8;
    localparam int WIDTH_W  = 7;
    localparam int HEIGHT_W = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int BPR_W    = 5;
    localparam int PROD_W   = WIDTH_W + HEIGHT_W;
    localparam int ADDR_W   = 16;
    localparam int COEF_W   = 16;
    localparam int ACC_W    = 24;
    localparam int IDX_W    = 2;

    // Actions
    localparam logic [ACTION_W-1:0] ACT_READ_RGB  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_READ_BIT  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE_RGB = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_WRITE_BIT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd4;

    // Store layouts
    localparam logic FMT_RGB  = 1'b0;
    localparam logic FMT_MONO = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INK_BLUE  = 3'd5;

    // Byte offsets inside an RGB pixel
    localparam logic [IDX_W-1:0] IDX_RED   = 2'd0;
    localparam logic [IDX_W-1:0] IDX_GREEN = 2'd1;
    localparam logic [IDX_W-1:0] IDX_BLUE  = 2'd2;

    // Rec.601 luma weights, 16-bit fixed point
    localparam logic [COEF_W-1:0] LUMA_WR = 16'd19595;
    localparam logic [COEF_W-1:0] LUMA_WG = 16'd38470;
    localparam logic [COEF_W-1:0] LUMA_WB = 16'd7471;
    localparam logic [COLOR_W-1:0] MONO_WRITE_CUT = 8'd128;
    localparam logic [COLOR_W-1:0] MONO_MSB_MASK  = 8'h80;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic                      on;
        logic [COLOR_W-1:0]        cutoff;
    } item_t;

    typedef struct packed {
        logic [COLOR_W-1:0] out_red;
        logic [COLOR_W-1:0] out_green;
        logic [COLOR_W-1:0] out_blue;
        logic               out_on;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic             take;
        logic             mul;
        logic             adr;
        logic             luma;
        logic             rd;
        logic             wr;
        logic             resp;
        logic             clr;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                format;
        logic                in_canvas;
        logic                out_busy;
        logic                clr_last;
    } status_t;

    function automatic logic [COEF_W-1:0] luma_coef(input logic [IDX_W-1:0] idx);
        logic [COEF_W-1:0] c;
        case (idx)
            IDX_RED:   c = LUMA_WR;
            IDX_GREEN: c = LUMA_WG;
            default:   c = LUMA_WB;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/pcs_if.sv
// Valid/ready channel interfaces for pixel items and read results.
`timescale 1ns / 1ps
`default_nettype none
interface pcs_in_if;
    logic                                    valid;
    logic                                    ready;
    logic [pcs_pkg::ACTION_W-1:0]            action;
    logic signed [pcs_pkg::COORD_W-1:0]      x;
    logic signed [pcs_pkg::COORD_W-1:0]      y;
    logic [pcs_pkg::COLOR_W-1:0]             red;
    logic [pcs_pkg::COLOR_W-1:0]             green;
    logic [pcs_pkg::COLOR_W-1:0]             blue;
    logic                                    on;
    logic [pcs_pkg::COLOR_W-1:0]             cutoff;

    modport source (
        output valid, action, x, y, red, green, blue, on, cutoff,
        input  ready
    );
    modport sink (
        input  valid, action, x, y, red, green, blue, on, cutoff,
        output ready
    );
endinterface

interface pcs_out_if;
    logic                        valid;
    logic                        ready;
    logic [pcs_pkg::COLOR_W-1:0] out_red;
    logic [pcs_pkg::COLOR_W-1:0] out_green;
    logic [pcs_pkg::COLOR_W-1:0] out_blue;
    logic                        out_on;

    modport source (
        output valid, out_red, out_green, out_blue, out_on,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_on,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/pcs_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pcs_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DATA_W-1:0]        wdata,
    output logic      [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pcs_ctrl.sv
// Controller state machine sequencing store accesses for one item at a time.
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire pcs_pkg::status_t stat,
    output pcs_pkg::cmd_t         cmd
);
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_ADR,
        S_LUMA,
        S_RD,
        S_RDW,
        S_WR,
        S_RESP
    } state_t;

    state_t                       state_reg, state_next;
    logic [pcs_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                         is_read;
    logic [pcs_pkg::IDX_W-1:0]    rd_last;
    logic [pcs_pkg::IDX_W-1:0]    wr_last;

    assign is_read = (stat.action == pcs_pkg::ACT_READ_RGB) ||
                     (stat.action == pcs_pkg::ACT_READ_BIT);
    assign rd_last = (is_read && stat.format == pcs_pkg::FMT_RGB) ? pcs_pkg::IDX_BLUE
                                                                  : pcs_pkg::IDX_RED;
    assign wr_last = (stat.format == pcs_pkg::FMT_RGB) ? pcs_pkg::IDX_BLUE
                                                       : pcs_pkg::IDX_RED;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.action == pcs_pkg::ACT_CLEAR)
                begin
                    state_next = S_CLEAR;
                end
                else if (stat.action > pcs_pkg::ACT_CLEAR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ADR;
                end
            end
            S_ADR:
            begin
                cmd.adr  = 1'b1;
                idx_next = pcs_pkg::IDX_RED;
                if (!stat.in_canvas)
                begin
                    state_next = is_read ? S_RESP : S_IDLE;
                end
                else if (is_read)
                begin
                    state_next = S_RD;
                end
                else if (stat.format == pcs_pkg::FMT_RGB)
                begin
                    state_next = S_WR;
                end
                else if (stat.action == pcs_pkg::ACT_WRITE_RGB)
                begin
                    state_next = S_LUMA;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_LUMA:
            begin
                cmd.luma = 1'b1;
                if (idx_reg == pcs_pkg::IDX_BLUE)
                begin
                    idx_next   = pcs_pkg::IDX_RED;
                    state_next = S_RD;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RD:
            begin
                cmd.rd = 1'b1;
                if (idx_reg == rd_last)
                begin
                    idx_next   = pcs_pkg::IDX_RED;
                    state_next = S_RDW;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RDW:
            begin
                state_next = is_read ? S_RESP : S_WR;
            end
            S_WR:
            begin
                cmd.wr = 1'b1;
                if (idx_reg == wr_last)
                begin
                    idx_next   = pcs_pkg::IDX_RED;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (!stat.out_busy)
                begin
                    cmd.resp   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg   <= pcs_pkg::IDX_RED;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/pcs_datapath.sv
// Datapath: configuration, address arithmetic, luma unit, store and result word.
`timescale 1ns / 1ps
`default_nettype none
module pcs_datapath #(
    parameter int MAX_WIDTH   = pcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = pcs_pkg::MAX_HEIGHT_DEF,
    parameter int STORE_BYTES = pcs_pkg::STORE_BYTES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire pcs_pkg::item_t                    in_word,
    input  wire pcs_pkg::cmd_t                     cmd,
    output pcs_pkg::status_t                       stat,
    output pcs_pkg::result_t                       out_word,
    output logic                                   out_valid,
    input  wire logic                              out_ready
);
    localparam int RAM_AW = $clog2(STORE_BYTES);
    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);
    localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(STORE_BYTES - 1);

    localparam int WW = pcs_pkg::WIDTH_W;
    localparam int HW = pcs_pkg::HEIGHT_W;
    localparam int CW = pcs_pkg::COLOR_W;
    localparam int AW = pcs_pkg::ADDR_W;

    // configuration
    logic [WW-1:0] width_reg;
    logic [HW-1:0] height_reg;
    logic          format_reg;
    logic [CW-1:0] ink_red_reg, ink_green_reg, ink_blue_reg;

    pcs_pkg::item_t item_reg;

    logic [WW-1:0]                used_w;
    logic [HW-1:0]                used_h;
    logic [pcs_pkg::BPR_W-1:0]    bytes_per_row;
    logic                         in_canvas;
    logic [WW-1:0]                col;
    logic [HW-1:0]                row;
    logic [WW-1:0]                mul_op;
    logic [pcs_pkg::PROD_W-1:0]   prod_reg;
    logic [pcs_pkg::PROD_W:0]     rgb_lin;
    logic [AW-1:0]                rgb_base, mono_base;
    logic [AW-1:0]                base_reg;
    logic [AW-1:0]                acc_addr;
    logic                         in_store;

    logic [RAM_AW-1:0]            clr_cnt_reg;
    logic                         ram_we, ram_re;
    logic [RAM_AW-1:0]            ram_addr;
    logic [CW-1:0]                ram_wdata, ram_rdata;

    logic                         rd_valid_reg, rd_hit_reg;
    logic [pcs_pkg::IDX_W-1:0]    rd_idx_reg;
    logic [CW-1:0]                rd_byte;
    logic [CW-1:0]                red_b_reg, green_b_reg, blue_b_reg;

    logic [pcs_pkg::IDX_W-1:0]    coef_idx;
    logic [CW-1:0]                in_color, ink_color, mul_byte;
    logic [pcs_pkg::ACC_W-1:0]    mul_prod;
    logic [pcs_pkg::ACC_W-1:0]    acc_reg;
    logic [CW-1:0]                luma;

    logic [CW-1:0]                mask;
    logic                         set_bit;
    logic                         mono_bit;
    logic [CW-1:0]                wr_byte;
    pcs_pkg::result_t             res_next;
    pcs_pkg::result_t             out_word_reg;
    logic                         out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 7'd64;
            height_reg    <= 6'd32;
            format_reg    <= pcs_pkg::FMT_RGB;
            ink_red_reg   <= 8'd255;
            ink_green_reg <= 8'd255;
            ink_blue_reg  <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcs_pkg::CFG_WIDTH:     width_reg     <= cfg_data[WW-1:0];
                pcs_pkg::CFG_HEIGHT:    height_reg    <= cfg_data[HW-1:0];
                pcs_pkg::CFG_FORMAT:    format_reg    <= cfg_data[0];
                pcs_pkg::CFG_INK_RED:   ink_red_reg   <= cfg_data;
                pcs_pkg::CFG_INK_GREEN: ink_green_reg <= cfg_data;
                pcs_pkg::CFG_INK_BLUE:  ink_blue_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_reg <= in_word;
        end
    end

    // canvas bounds
    assign used_w = (32'(width_reg) > MAX_W32) ? MAX_W32[WW-1:0] : width_reg;
    assign used_h = (32'(height_reg) > MAX_H32) ? MAX_H32[HW-1:0] : height_reg;
    assign bytes_per_row = pcs_pkg::BPR_W'((8'(used_w) + 8'd7) >> 3);
    assign in_canvas = !item_reg.x[pcs_pkg::COORD_W-1] && !item_reg.y[pcs_pkg::COORD_W-1] &&
                       (item_reg.x[pcs_pkg::COORD_W-2:0] < 15'(used_w)) &&
                       (item_reg.y[pcs_pkg::COORD_W-2:0] < 15'(used_h));
    assign col = item_reg.x[WW-1:0];
    assign row = item_reg.y[HW-1:0];

    // row offset product, then byte base address
    assign mul_op = (format_reg == pcs_pkg::FMT_MONO) ? WW'(bytes_per_row) : used_w;
    assign rgb_lin   = (pcs_pkg::PROD_W + 1)'(prod_reg) + (pcs_pkg::PROD_W + 1)'(col);
    assign rgb_base  = AW'(rgb_lin) + AW'({rgb_lin, 1'b0});
    assign mono_base = AW'(prod_reg) + AW'(col[WW-1:3]);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= pcs_pkg::PROD_W'(row) * pcs_pkg::PROD_W'(mul_op);
        end
        if (cmd.adr)
        begin
            base_reg <= (format_reg == pcs_pkg::FMT_MONO) ? mono_base : rgb_base;
        end
    end

    assign acc_addr = base_reg + AW'(cmd.idx);
    assign in_store = 32'(acc_addr) < 32'(STORE_BYTES);

    // store access
    assign ram_we    = cmd.clr | (cmd.wr & in_store);
    assign ram_re    = cmd.rd & in_store;
    assign ram_addr  = cmd.clr ? clr_cnt_reg : RAM_AW'(acc_addr);
    assign ram_wdata = cmd.clr ? '0 : wr_byte;

    pcs_ram #(
        .DATA_W (CW),
        .DEPTH  (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            rd_valid_reg <= 1'b0;
            rd_hit_reg   <= 1'b0;
            rd_idx_reg   <= pcs_pkg::IDX_RED;
        end
        else
        begin
            if (cmd.clr)
            begin
                clr_cnt_reg <= (clr_cnt_reg == CLR_LAST) ? '0 : clr_cnt_reg + 1'b1;
            end
            rd_valid_reg <= cmd.rd;
            rd_hit_reg   <= ram_re;
            rd_idx_reg   <= cmd.idx;
        end
    end

    assign rd_byte = rd_hit_reg ? ram_rdata : '0;

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            case (rd_idx_reg)
                pcs_pkg::IDX_RED:   red_b_reg   <= rd_byte;
                pcs_pkg::IDX_GREEN: green_b_reg <= rd_byte;
                default:            blue_b_reg  <= rd_byte;
            endcase
        end
    end

    // luma unit: one weighted component per cycle
    always_comb
    begin
        case (cmd.idx)
            pcs_pkg::IDX_RED:
            begin
                in_color  = item_reg.red;
                ink_color = ink_red_reg;
            end
            pcs_pkg::IDX_GREEN:
            begin
                in_color  = item_reg.green;
                ink_color = ink_green_reg;
            end
            default:
            begin
                in_color  = item_reg.blue;
                ink_color = ink_blue_reg;
            end
        endcase
    end

    assign coef_idx = rd_valid_reg ? rd_idx_reg : cmd.idx;
    assign mul_byte = rd_valid_reg ? rd_byte : in_color;
    assign mul_prod = pcs_pkg::ACC_W'(pcs_pkg::luma_coef(coef_idx)) *
                      pcs_pkg::ACC_W'(mul_byte);

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            acc_reg <= '0;
        end
        else if (cmd.luma || (rd_valid_reg && format_reg == pcs_pkg::FMT_RGB))
        begin
            acc_reg <= acc_reg + mul_prod;
        end
    end

    assign luma = acc_reg[pcs_pkg::ACC_W-1:pcs_pkg::ACC_W-CW];

    // write byte
    assign mask    = pcs_pkg::MONO_MSB_MASK >> col[2:0];
    assign set_bit = (item_reg.action == pcs_pkg::ACT_WRITE_RGB) ?
                     (luma >= pcs_pkg::MONO_WRITE_CUT) : item_reg.on;
    assign mono_bit = |(red_b_reg & mask);

    always_comb
    begin
        if (format_reg == pcs_pkg::FMT_MONO)
        begin
            wr_byte = set_bit ? (red_b_reg | mask) : (red_b_reg & ~mask);
        end
        else if (item_reg.action == pcs_pkg::ACT_WRITE_RGB)
        begin
            wr_byte = in_color;
        end
        else
        begin
            wr_byte = item_reg.on ? ink_color : '0;
        end
    end

    // result word
    always_comb
    begin
        res_next = '0;
        if (in_canvas)
        begin
            if (format_reg == pcs_pkg::FMT_RGB)
            begin
                if (item_reg.action == pcs_pkg::ACT_READ_RGB)
                begin
                    res_next.out_red   = red_b_reg;
                    res_next.out_green = green_b_reg;
                    res_next.out_blue  = blue_b_reg;
                end
                else
                begin
                    res_next.out_on = (luma >= item_reg.cutoff);
                end
            end
            else
            begin
                if (item_reg.action == pcs_pkg::ACT_READ_RGB)
                begin
                    res_next.out_red   = mono_bit ? ink_red_reg : '0;
                    res_next.out_green = mono_bit ? ink_green_reg : '0;
                    res_next.out_blue  = mono_bit ? ink_blue_reg : '0;
                end
                else
                begin
                    res_next.out_on = mono_bit;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp)
        begin
            out_word_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.resp)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_word  = out_word_reg;
    assign out_valid = out_valid_reg;

    assign stat.action    = item_reg.action;
    assign stat.format    = format_reg;
    assign stat.in_canvas = in_canvas;
    assign stat.out_busy  = out_valid_reg & ~out_ready;
    assign stat.clr_last  = (clr_cnt_reg == CLR_LAST);
endmodule
`default_nettype wire

FILE: rtl/pixel_canvas_store.sv
// Pixel canvas store: top level joining the controller, the datapath and the channels.
// A read's word goes through the address product, the base address, the byte reads (one
//   on a mono store, three on an RGB store, none outside the canvas), then the result
//   register, which waits while the previous word is not yet accepted.
// Items are taken one at a time, paced by the byte-wide single-port store that
//   serves the three bytes of an RGB pixel one per cycle.
// Clear walks the store one byte a cycle.
// Reset: a clearing pass zeroes the store; item.ready stays low meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module pixel_canvas_store #(
    parameter int MAX_WIDTH   = pcs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = pcs_pkg::MAX_HEIGHT_DEF,
    parameter int STORE_BYTES = pcs_pkg::STORE_BYTES_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    pcs_in_if.sink                              item,
    pcs_out_if.source                           result,
    input  wire logic                           cfg_we,
    input  wire logic [pcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcs_pkg::CFG_DATA_W-1:0] cfg_data
);
    pcs_pkg::item_t   in_word;
    pcs_pkg::result_t out_word;
    pcs_pkg::cmd_t    cmd;
    pcs_pkg::status_t stat;
    logic             in_ready;
    logic             out_valid;

    // Gather the incoming word; the datapath latches it when the controller takes it.
    assign in_word.action = item.action;
    assign in_word.x      = item.x;
    assign in_word.y      = item.y;
    assign in_word.red    = item.red;
    assign in_word.green  = item.green;
    assign in_word.blue   = item.blue;
    assign in_word.on     = item.on;
    assign in_word.cutoff = item.cutoff;
    assign item.ready     = in_ready;

    // Sequence the store accesses: accept, address, luma or reads, writes, respond.
    pcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold configuration, compute addresses and luma, own the store and the result word.
    pcs_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word),
        .cmd       (cmd),
        .stat      (stat),
        .out_word  (out_word),
        .out_valid (out_valid),
        .out_ready (result.ready)
    );

    // The result word waits in its register; the next item may be taken meanwhile.
    assign result.valid     = out_valid;
    assign result.out_red   = out_word.out_red;
    assign result.out_green = out_word.out_green;
    assign result.out_blue  = out_word.out_blue;
    assign result.out_on    = out_word.out_on;
endmodule
`default_nettype wire

FILE: dv/tb_pixel_canvas_store.sv
// Testbench for pixel_canvas_store: self-checking random and directed regression.
`timescale 1ns / 1ps
module tb_pixel_canvas_store;
    import pcs_pkg::*;

    // Action and register codes that the package leaves unnamed: the block must ignore them
    localparam logic [ACTION_W-1:0]  ACT_RSVD5     = 3'd5;
    localparam logic [ACTION_W-1:0]  ACT_RSVD6     = 3'd6;
    localparam logic [ACTION_W-1:0]  ACT_RSVD7     = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED7 = 3'd7;

    // A clear walks the whole store, and so does the pass after reset;
    // the quiet limit covers either of those several times over, stalls included.
    localparam int QUIET_LIMIT   = 40000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 16;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pcs_in_if  item_if ();
    pcs_out_if result_if ();

    pixel_canvas_store dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Canvas mirror: our own copy of the store bytes and the registers.
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0]  canvas_bytes [STORE_BYTES_DEF];
    logic [WIDTH_W-1:0]  cur_width;
    logic [HEIGHT_W-1:0] cur_height;
    logic                cur_format;
    logic [COLOR_W-1:0]  ink_red;
    logic [COLOR_W-1:0]  ink_green;
    logic [COLOR_W-1:0]  ink_blue;

    result_t pending_reads [$];   // read words owed by the block, oldest first
    int      mismatches  = 0;
    int      burst_left  = 0;     // words left in the current sender burst
    int      holds_asked = 0;     // bumped by a test to request a long result stall

    function automatic int used_width();
        return (int'(cur_width) > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cur_width);
    endfunction

    function automatic int used_height();
        return (int'(cur_height) > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cur_height);
    endfunction

    function automatic logic [COLOR_W-1:0] load_byte(input int addr);
        return (addr < STORE_BYTES_DEF) ? canvas_bytes[addr] : '0;
    endfunction

    function automatic void store_byte(input int addr, input logic [COLOR_W-1:0] v);
        if (addr < STORE_BYTES_DEF)
        begin
            canvas_bytes[addr] = v;
        end
    endfunction

    // Rec.601 luma in 16-bit fixed point, truncated
    function automatic logic [COLOR_W-1:0] luma_of(input logic [COLOR_W-1:0] r,
                                                   input logic [COLOR_W-1:0] g,
                                                   input logic [COLOR_W-1:0] b);
        logic [31:0] acc;
        acc = 32'(LUMA_WR) * 32'(r) + 32'(LUMA_WG) * 32'(g) + 32'(LUMA_WB) * 32'(b);
        return acc[23:16];
    endfunction

    function automatic int rgb_base(input int px, input int py);
        return (py * used_width() + px) * 3;
    endfunction

    // Mono rows are padded to whole bytes
    function automatic int mono_base(input int px, input int py);
        return py * ((used_width() + 7) / 8) + px / 8;
    endfunction

    // Advance the mirror by one accepted word and queue the read word it owes, if any.
    function automatic void apply_pixel_action(input item_t w);
        int                 sx;
        int                 sy;
        int                 base;
        logic               hit;
        logic               lit;
        logic [COLOR_W-1:0] mask;
        result_t            due;
        sx   = int'(w.x);
        sy   = int'(w.y);
        hit  = (sx >= 0) && (sy >= 0) && (sx < used_width()) && (sy < used_height());
        mask = MONO_MSB_MASK >> (sx % 8);
        due  = '0;
        case (w.action)
            ACT_CLEAR:
            begin
                foreach (canvas_bytes[i])
                begin
                    canvas_bytes[i] = '0;
                end
            end
            ACT_READ_RGB, ACT_READ_BIT:
            begin
                // Outside the canvas every field reads as zero
                if (hit && cur_format == FMT_RGB)
                begin
                    base = rgb_base(sx, sy);
                    if (w.action == ACT_READ_RGB)
                    begin
                        due.out_red   = load_byte(base);
                        due.out_green = load_byte(base + 1);
                        due.out_blue  = load_byte(base + 2);
                    end
                    else
                    begin
                        due.out_on = luma_of(load_byte(base), load_byte(base + 1),
                                             load_byte(base + 2)) >= w.cutoff;
                    end
                end
                else if (hit)
                begin
                    lit = (load_byte(mono_base(sx, sy)) & mask) != '0;
                    if (w.action == ACT_READ_RGB)
                    begin
                        due.out_red   = lit ? ink_red   : '0;
                        due.out_green = lit ? ink_green : '0;
                        due.out_blue  = lit ? ink_blue  : '0;
                    end
                    else
                    begin
                        due.out_on = lit;
                    end
                end
                pending_reads.push_back(due);
            end
            ACT_WRITE_RGB, ACT_WRITE_BIT:
            begin
                if (hit && w.action == ACT_WRITE_RGB && cur_format == FMT_RGB)
                begin
                    base = rgb_base(sx, sy);
                    store_byte(base,     w.red);
                    store_byte(base + 1, w.green);
                    store_byte(base + 2, w.blue);
                end
                else if (hit)
                begin
                    // Colour into a mono store keeps luma >= 128; a bit into an RGB
                    // store becomes the ink colour or black
                    lit = (w.action == ACT_WRITE_RGB) ?
                          (luma_of(w.red, w.green, w.blue) >= MONO_WRITE_CUT) : w.on;
                    if (cur_format == FMT_MONO)
                    begin
                        base = mono_base(sx, sy);
                        store_byte(base, lit ? (load_byte(base) | mask)
                                             : (load_byte(base) & ~mask));
                    end
                    else
                    begin
                        base = rgb_base(sx, sy);
                        store_byte(base,     lit ? ink_red   : '0);
                        store_byte(base + 1, lit ? ink_green : '0);
                        store_byte(base + 2, lit ? ink_blue  : '0);
                    end
                end
            end
            default:
            begin
                // reserved actions: no effect, no word
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t pixel_word(input logic [ACTION_W-1:0] action, input int x,
                                         input int y, input int r, input int g,
                                         input int b, input int on, input int cutoff);
        item_t w;
        w        = '0;
        w.action = action;
        w.x      = 16'(x);
        w.y      = 16'(y);
        w.red    = 8'(r);
        w.green  = 8'(g);
        w.blue   = 8'(b);
        w.on     = 1'(on);
        w.cutoff = 8'(cutoff);
        return w;
    endfunction

    // Mostly well-formed traffic inside the canvas, a hot corner so reads hit earlier
    // writes, edge misses, wild coordinates, rare clears and the odd reserved action.
    function automatic item_t random_word();
        item_t w;
        int    uw;
        int    uh;
        int    pick;
        int    spot;
        int    gray;
        int    x;
        int    y;
        uw       = used_width();
        uh       = used_height();
        w        = '0;
        w.red    = 8'($urandom_range(0, 255));
        w.green  = 8'($urandom_range(0, 255));
        w.blue   = 8'($urandom_range(0, 255));
        w.on     = 1'($urandom_range(0, 1));
        w.cutoff = 8'($urandom_range(0, 255));
        pick     = $urandom_range(0, 199);
        if (pick < 2)
        begin
            w.action = ACT_CLEAR;
        end
        else if (pick < 6)
        begin
            case ($urandom_range(0, 2))
                0:       w.action = ACT_RSVD5;
                1:       w.action = ACT_RSVD6;
                default: w.action = ACT_RSVD7;
            endcase
        end
        else if (pick < 66)
        begin
            w.action = ACT_READ_RGB;
        end
        else if (pick < 116)
        begin
            w.action = ACT_READ_BIT;
        end
        else if (pick < 166)
        begin
            w.action = ACT_WRITE_RGB;
        end
        else
        begin
            w.action = ACT_WRITE_BIT;
        end
        // Grays around the mono write cut land exactly on their own luma
        if ($urandom_range(0, 9) == 0)
        begin
            gray    = $urandom_range(124, 132);
            w.red   = 8'(gray);
            w.green = 8'(gray);
            w.blue  = 8'(gray);
            w.cutoff = 8'($urandom_range(gray - 1, gray + 1));
        end
        spot = $urandom_range(0, 99);
        if (uw == 0 || uh == 0 || spot < 8)
        begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
            if (spot >= 8)
            begin
                x = $urandom_range(0, 4) - 2;
                y = $urandom_range(0, 4) - 2;
            end
        end
        else if (spot < 18)
        begin
            x = $urandom_range(0, uw - 1);
            y = $urandom_range(0, uh - 1);
            case ($urandom_range(0, 3))
                0:       x = -1;
                1:       x = uw;
                2:       y = -1;
                default: y = uh;
            endcase
        end
        else if (spot < 60)
        begin
            x = $urandom_range(0, ((uw < 10) ? uw : 10) - 1);
            y = $urandom_range(0, ((uh < 4) ? uh : 4) - 1);
        end
        else
        begin
            x = $urandom_range(0, uw - 1);
            y = $urandom_range(0, uh - 1);
        end
        w.x = 16'(x);
        w.y = 16'(y);
        return w;
    endfunction

    // Offer one word and hold it until taken. Bursts of random length with random
    // gaps between them; a zero gap joins two bursts into one long stretch.
    task automatic send_word(input item_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_if.valid  <= 1'b1;
        item_if.action <= w.action;
        item_if.x      <= w.x;
        item_if.y      <= w.y;
        item_if.red    <= w.red;
        item_if.green  <= w.green;
        item_if.blue   <= w.blue;
        item_if.on     <= w.on;
        item_if.cutoff <= w.cutoff;
        do
            @(posedge clk);
        while (item_if.ready !== 1'b1);
        apply_pixel_action(w);
    endtask

    // Write one register at an edge and mirror it; we drops for a cycle between writes.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_WIDTH:     cur_width  = data[WIDTH_W-1:0];
            CFG_HEIGHT:    cur_height = data[HEIGHT_W-1:0];
            CFG_FORMAT:    cur_format = data[0];
            CFG_INK_RED:   ink_red    = data;
            CFG_INK_GREEN: ink_green  = data;
            CFG_INK_BLUE:  ink_blue   = data;
            default:
            begin
                // unmapped index: ignored
            end
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Bring the block to idle. Writes and clears give no word, so send a read outside
    // the canvas: its word can only come once all earlier work, clears included, is
    // done. Then drain the queue and let the pipeline run dry.
    task automatic settle_canvas();
        send_word(pixel_word(ACT_READ_BIT, -1, $urandom_range(0, 40), 0, 0, 0, 0,
                             $urandom_range(0, 255)));
        item_if.valid <= 1'b0;
        while (pending_reads.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Store comes up cleared at 64x32 RGB. A black pixel still passes a zero cutoff.
    task automatic test_reset_state();
        send_word(pixel_word(ACT_READ_RGB, 0, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_BIT, 63, 31, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_BIT, 63, 31, 0, 0, 0, 0, 1));
        settle_canvas();
    endtask

    // RGB layout: corners, luma cutoff on both sides, bits written as ink or black,
    // coordinates outside the canvas, reserved actions and a clear.
    task automatic test_rgb_layout();
        send_word(pixel_word(ACT_WRITE_RGB, 0, 0, 255, 255, 255, 0, 0));
        send_word(pixel_word(ACT_WRITE_RGB, 63, 31, 200, 100, 50, 0, 0));
        send_word(pixel_word(ACT_READ_RGB, 63, 31, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_BIT, 0, 0, 0, 0, 0, 0, 255));
        // luma of (200,100,50) truncates to 124
        send_word(pixel_word(ACT_READ_BIT, 63, 31, 0, 0, 0, 0, 124));
        send_word(pixel_word(ACT_READ_BIT, 63, 31, 0, 0, 0, 0, 125));
        send_word(pixel_word(ACT_WRITE_BIT, 1, 0, 0, 0, 0, 1, 0));
        send_word(pixel_word(ACT_WRITE_BIT, 0, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_RGB, 1, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_RGB, 0, 0, 0, 0, 0, 0, 0));
        // outside: writes drop, reads give zero
        send_word(pixel_word(ACT_WRITE_RGB, 64, 0, 9, 9, 9, 0, 0));
        send_word(pixel_word(ACT_WRITE_BIT, 32767, -32768, 0, 0, 0, 1, 0));
        send_word(pixel_word(ACT_READ_BIT, -32768, 32767, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_RGB, 0, 32, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_RSVD5, 1, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_RSVD6, 1, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_RSVD7, 1, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_RGB, 1, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_RGB, 1, 0, 0, 0, 0, 0, 0));
        settle_canvas();
    endtask

    // Mono layout on a 13-wide canvas (rows padded to two bytes), the mono write cut
    // at luma 127/128, then a switch back to RGB that reads the same bytes as colour.
    task automatic test_mono_layout();
        write_reg(CFG_WIDTH, 8'h8D);          // bit 7 lies outside the register
        write_reg(CFG_FORMAT, 8'h01);
        write_reg(CFG_INK_RED, 8'h00);
        write_reg(CFG_INK_GREEN, 8'hA5);
        write_reg(CFG_INK_BLUE, 8'hFF);
        send_word(pixel_word(ACT_WRITE_RGB, 12, 0, 128, 128, 128, 0, 0));
        send_word(pixel_word(ACT_WRITE_RGB, 11, 0, 127, 127, 127, 0, 0));
        send_word(pixel_word(ACT_WRITE_BIT, 0, 1, 0, 0, 0, 1, 0));
        send_word(pixel_word(ACT_READ_RGB, 12, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_BIT, 11, 0, 0, 0, 0, 0, 0));
        send_word(pixel_word(ACT_READ_BIT, 0, 1, 0, 0, 0, 0, 0));
        settle_canvas();
        write_reg(CFG_FORMAT, 8'hFE);
        send_word(pixel_word(ACT_READ_RGB, 0, 0, 0, 0, 0, 0, 0));
        settle_canvas();
    endtask

    // Extreme sizes: oversized width and height, zero width, zero height, a single
    // pixel, just past the maximum; plus writes to unmapped register indexes.
    task automatic test_size_extremes();
        logic [CFG_DATA_W-1:0] wdat [5];
        logic [CFG_DATA_W-1:0] hdat [5];
        wdat = '{8'hFF, 8'h80, 8'd64, 8'd1, 8'd65};
        hdat = '{8'hFF, 8'd32, 8'h40, 8'd1, 8'd33};
        for (int i = 0; i < 5; i++)
        begin
            write_reg(CFG_WIDTH, wdat[i]);
            write_reg(CFG_HEIGHT, hdat[i]);
            write_reg(CFG_FORMAT, 8'(i % 2));
            write_reg((i % 2 != 0) ? CFG_UNMAPPED7 : CFG_UNMAPPED6,
                      8'($urandom_range(0, 255)));
            repeat (40) send_word(random_word());
            settle_canvas();
        end
    endtask

    // Random rounds, each under fresh settings; the store is not cleared between them,
    // so a layout change reads old bytes the new way.
    task automatic test_random_traffic();
        int w7;
        int h6;
        for (int round = 0; round < 8; round++)
        begin
            case ($urandom_range(0, 11))
                0:       w7 = 0;
                1:       w7 = $urandom_range(65, 127);
                default: w7 = $urandom_range(1, 64);
            endcase
            case ($urandom_range(0, 11))
                0:       h6 = 0;
                1:       h6 = $urandom_range(33, 63);
                default: h6 = $urandom_range(1, 32);
            endcase
            write_reg(CFG_WIDTH, {1'($urandom_range(0, 1)), 7'(w7)});
            write_reg(CFG_HEIGHT, {2'($urandom_range(0, 3)), 6'(h6)});
            write_reg(CFG_FORMAT, 8'($urandom_range(0, 255)));
            write_reg(CFG_INK_RED, 8'($urandom_range(0, 255)));
            write_reg(CFG_INK_GREEN, 8'($urandom_range(0, 255)));
            write_reg(CFG_INK_BLUE, 8'($urandom_range(0, 255)));
            repeat (170) send_word(random_word());
            settle_canvas();
        end
    endtask

    // Ask the result side for a long stall and keep offering reads so the block fills
    // up and has to drop item.ready.
    task automatic test_backpressure();
        item_t w;
        write_reg(CFG_WIDTH, 8'd64);
        write_reg(CFG_HEIGHT, 8'd32);
        holds_asked++;
        repeat (40)
        begin
            w        = random_word();
            w.action = ($urandom_range(0, 1) != 0) ? ACT_READ_RGB : ACT_READ_BIT;
            send_word(w);
        end
        settle_canvas();
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern of its own, plus the long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : result_stall_pattern
        int hold_left;
        int mode_left;
        int stall_pct;
        int holds_seen;
        hold_left  = 0;
        mode_left  = 0;
        stall_pct  = 0;
        holds_seen = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_seen != holds_asked)
            begin
                holds_seen = holds_asked;
                hold_left  = HOLD_CYCLES;
            end
            // switch stall density whenever the current mode runs out, never-stall among them
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Check each read word against the oldest one owed
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [COLOR_W-1:0] want,
                                        input logic [COLOR_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_read_words
        result_t due;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("read word with nothing owed: red %0d green %0d blue %0d on %0d",
                       result_if.out_red, result_if.out_green, result_if.out_blue,
                       result_if.out_on);
                mismatches++;
            end
            else
            begin
                due = pending_reads.pop_front();
                check_field("out_red", due.out_red, result_if.out_red);
                check_field("out_green", due.out_green, result_if.out_green);
                check_field("out_blue", due.out_blue, result_if.out_blue);
                check_field("out_on", 8'(due.out_on), 8'(result_if.out_on));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when nothing moves on either channel for too long
    // ------------------------------------------------------------------
    initial
    begin : quiet_watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_if.valid === 1'b1 && item_if.ready === 1'b1) ||
                (result_if.valid === 1'b1 && result_if.ready === 1'b1))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("pixel_canvas_store regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : run_tests
        // Drive every input to a known value from time zero
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_WIDTH;
        cfg_data       <= '0;
        item_if.valid  <= 1'b0;
        item_if.action <= ACT_READ_RGB;
        item_if.x      <= '0;
        item_if.y      <= '0;
        item_if.red    <= '0;
        item_if.green  <= '0;
        item_if.blue   <= '0;
        item_if.on     <= 1'b0;
        item_if.cutoff <= '0;

        // Mirror the reset state: store cleared, 64x32 RGB, white ink
        foreach (canvas_bytes[i])
        begin
            canvas_bytes[i] = '0;
        end
        cur_width  = WIDTH_W'(MAX_WIDTH_DEF);
        cur_height = HEIGHT_W'(MAX_HEIGHT_DEF);
        cur_format = FMT_RGB;
        ink_red    = 8'hFF;
        ink_green  = 8'hFF;
        ink_blue   = 8'hFF;

        // Hold reset, then release it; the clearing pass that follows keeps item.ready
        // low, which the first handshake simply waits out
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_rgb_layout();
        test_mono_layout();
        test_size_extremes();
        test_random_traffic();
        test_backpressure();

        if (pending_reads.size() != 0)
        begin
            $error("%0d read words never arrived", pending_reads.size());
        end
        if (mismatches == 0 && pending_reads.size() == 0)
        begin
            $display("pixel_canvas_store regression: pass");
        end
        else
        begin
            $display("pixel_canvas_store regression: fail");
        end
        $finish;
    end

endmodule

FILE: pixel_canvas_store.f
rtl/pcs_pkg.sv
rtl/pcs_if.sv
rtl/pcs_ram.sv
rtl/pcs_ctrl.sv
rtl/pcs_datapath.sv
rtl/pixel_canvas_store.sv
dv/tb_pixel_canvas_store.sv
